FILE: rtl/joystick_differential_drive_shaper_core_macros.svh
// Assertion helpers for the checks in the shaper core.
`ifndef JOYSTICK_DIFFERENTIAL_DRIVE_SHAPER_CORE_MACROS_SVH
`define JOYSTICK_DIFFERENTIAL_DRIVE_SHAPER_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define JDDS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define JDDS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/jdds_pkg.sv
`default_nettype none
package jdds_pkg;

   localparam int RSP_DATA_W = 48;

   // Speed limits after the mix.
   localparam int SPEED_LIMIT = 250;
   typedef logic signed [8:0] speed_type;
   localparam speed_type SPEED_CAP = 9'sd249;

   // Governor in twentieths.
   localparam logic [4:0] GOV_RESET = 5'd5;
   localparam logic [4:0] GOV_TOP   = 5'd18;
   localparam logic [4:0] GOV_FLOOR = 5'd2;

   localparam logic [4:0] BRAKE_ESTOP = 5'd31;

   // Trigger bands and their profiles.
   localparam logic [7:0] TRIG_BAND_LOW  = 8'd80;
   localparam logic [7:0] TRIG_BAND_HIGH = 8'd160;
   localparam logic [6:0] SLEW_SLOW  = 7'd0;
   localparam logic [6:0] SLEW_MID   = 7'd40;
   localparam logic [6:0] SLEW_FAST  = 7'd80;
   localparam logic [4:0] BRAKE_SLOW = 5'd31;
   localparam logic [4:0] BRAKE_MID  = 5'd15;
   localparam logic [4:0] BRAKE_FAST = 5'd0;

   typedef enum logic [1:0] {
      PROF_SLOW = 2'd0,
      PROF_MID  = 2'd1,
      PROF_FAST = 2'd2,
      PROF_NONE = 2'd3
   } profile_type;

   // Divide by twenty: drop two bits, then multiply by a reciprocal of five.
   localparam int            MAG_W       = 13;
   localparam logic [12:0]   RECIP_FIVE  = 13'd6554;
   localparam int            RECIP_SHIFT = 15;

   // Button positions in the edge history.
   localparam int HIST_START  = 0;
   localparam int HIST_PAUSE  = 1;
   localparam int HIST_ESTOP  = 2;
   localparam int HIST_FASTER = 3;
   localparam int HIST_SLOWER = 4;

   typedef struct packed {
      logic       linked;
      logic       exit_button;
      logic       start_button;
      logic       pause_button;
      logic       estop_button;
      logic       faster_button;
      logic       slower_button;
      logic [7:0] trigger;
   } sample_type;

   typedef struct packed {
      logic       stop_issued;
      logic       brake_forced;
      logic       profile_applied;
      logic [6:0] slew_level;
      logic [4:0] brake_level;
      logic       speeds_sent;
      logic       paused_now;
      logic [4:0] governor_now;
      logic       exit_requested;
   } step_type;

endpackage
`default_nettype wire

FILE: rtl/joystick_differential_drive_shaper_core.sv
`default_nettype none
// Channel   Direction  Signals                        Contents
// req       in         req_tvalid/tready/tdata        one controller sample
// rsp       out        rsp_tvalid/tready/tdata        one shaped drive command
// csr       in         csr_wr_en/csr_wr_data          exit_ignored register
//
// One request is taken every cycle when the result side keeps up; each request
// yields exactly one result, which passes through the input register, the control
// stage, the governor multiply stage and the divide-by-twenty into the result register.
// The control stage holds all step state, which sets the rate.
// Reset is synchronous and active high; it empties the pipeline and restores
// paused, governor 5, no profile, zero speeds and released buttons.
// A stalled result holds its stage, and earlier stages keep filling until full.
module joystick_differential_drive_shaper_core #(
   parameter int AXIS_WIDTH = 16,
   parameter int MIX_SHIFT  = 7
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // Request tdata, low bit up: linked, exit_button, start_button,
   // pause_button, estop_button, faster_button, slower_button,
   // throttle_x, throttle_y, trigger, zero fill.
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [((2*AXIS_WIDTH+15+7)/8)*8-1:0] req_tdata,
   // Response tdata, low bit up: stop_issued, brake_forced, profile_applied,
   // slew_level, brake_level, speeds_sent, left_speed, right_speed,
   // paused_now, governor_now, exit_requested, zero fill.
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [jdds_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   input  logic                                 csr_wr_en,
   input  logic                                 csr_wr_data
);
   import jdds_pkg::*;

   localparam int XPOS = 7;
   localparam int YPOS = XPOS + AXIS_WIDTH;
   localparam int TPOS = YPOS + AXIS_WIDTH;

   // Pipeline occupancy, one bit per stage.
   logic v0_ff, v1_ff, v2_ff, v3_ff;
   logic rdy0, rdy1, rdy2, rdy3;
   logic load0, load1, load2, load3;

   logic exit_ignored_ff;

   sample_type                    sample_ff;
   logic signed [AXIS_WIDTH-1:0]  x_ff, y_ff;

   step_type  step1, step2_ff, step3_ff;
   speed_type left_mix, right_mix, left_scaled, right_scaled;
   speed_type left_ff, right_ff;

   // A stage may load when it is empty or its content moves on this cycle.
   assign rdy3  = !v3_ff || rsp_tready;
   assign rdy2  = !v2_ff || rdy3;
   assign rdy1  = !v1_ff || rdy2;
   assign rdy0  = !v0_ff || rdy1;
   assign load0 = req_tvalid && rdy0;
   assign load1 = v0_ff && rdy1;
   assign load2 = v1_ff && rdy2;
   assign load3 = v2_ff && rdy3;
   assign req_tready = rdy0;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (rdy0) v0_ff <= req_tvalid;
         if (rdy1) v1_ff <= v0_ff;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         exit_ignored_ff <= 1'b0;
      end else if (csr_wr_en) begin
         exit_ignored_ff <= csr_wr_data;
      end
   end

   // Input register: unpack the sample.
   always_ff @(posedge clock) begin
      if (load0) begin
         sample_ff.linked        <= req_tdata[0];
         sample_ff.exit_button   <= req_tdata[1];
         sample_ff.start_button  <= req_tdata[2];
         sample_ff.pause_button  <= req_tdata[3];
         sample_ff.estop_button  <= req_tdata[4];
         sample_ff.faster_button <= req_tdata[5];
         sample_ff.slower_button <= req_tdata[6];
         sample_ff.trigger       <= req_tdata[TPOS+7:TPOS];
         x_ff                    <= req_tdata[YPOS-1:XPOS];
         y_ff                    <= req_tdata[TPOS-1:YPOS];
      end
   end

   jdds_ctrl #(
      .AXIS_WIDTH (AXIS_WIDTH),
      .MIX_SHIFT  (MIX_SHIFT)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .advance      (load1),
      .exit_ignored (exit_ignored_ff),
      .sample       (sample_ff),
      .throttle_x   (x_ff),
      .throttle_y   (y_ff),
      .step         (step1),
      .left_mix     (left_mix),
      .right_mix    (right_mix)
   );

   // Both sides are scaled by the governor that stands after this step.
   jdds_scale u_scale_left (
      .clock    (clock),
      .load     (load2),
      .mix      (left_mix),
      .governor (step1.governor_now),
      .scaled   (left_scaled)
   );

   jdds_scale u_scale_right (
      .clock    (clock),
      .load     (load2),
      .mix      (right_mix),
      .governor (step1.governor_now),
      .scaled   (right_scaled)
   );

   always_ff @(posedge clock) begin
      if (load2) begin
         step2_ff <= step1;
      end
      if (load3) begin
         step3_ff <= step2_ff;
      end
   end

   // The commanded speeds are state: a stop zeroes them, a send replaces
   // them, and any other step leaves the last command in place.
   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff  <= '0;
         right_ff <= '0;
      end else if (load3) begin
         if (step2_ff.stop_issued) begin
            left_ff  <= '0;
            right_ff <= '0;
         end else if (step2_ff.speeds_sent) begin
            left_ff  <= left_scaled;
            right_ff <= right_scaled;
         end
      end
   end

   assign rsp_tvalid = v3_ff;
   assign rsp_tdata  = {7'b0,
                        step3_ff.exit_requested,
                        step3_ff.governor_now,
                        step3_ff.paused_now,
                        right_ff,
                        left_ff,
                        step3_ff.speeds_sent,
                        step3_ff.brake_level,
                        step3_ff.slew_level,
                        step3_ff.profile_applied,
                        step3_ff.brake_forced,
                        step3_ff.stop_issued};

`include "joystick_differential_drive_shaper_core_macros.svh"

   `JDDS_ASSERT_NOW(a_stop_send_exclusive, clock, reset, rsp_tvalid, !(step3_ff.stop_issued && step3_ff.speeds_sent), "stop and speed command in one result")
   `JDDS_ASSERT_NOW(a_governor_range, clock, reset, rsp_tvalid, (step3_ff.governor_now >= 5'd1) && (step3_ff.governor_now <= 5'd19), "governor out of range")
   `JDDS_ASSERT_NOW(a_estop_brake, clock, reset, rsp_tvalid && step3_ff.brake_forced, (step3_ff.brake_level == BRAKE_ESTOP) && step3_ff.paused_now, "emergency stop without full brake and pause")
   `JDDS_ASSERT_NEXT(a_exit_sticky, clock, reset, rsp_tvalid && rsp_tready && step3_ff.exit_requested, step3_ff.exit_requested, "exit state cleared")

endmodule
`default_nettype wire

FILE: rtl/jdds_ctrl.sv
`default_nettype none
module jdds_ctrl #(
   parameter int AXIS_WIDTH = 16,
   parameter int MIX_SHIFT  = 7
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         advance,
   input  logic                         exit_ignored,
   input  jdds_pkg::sample_type         sample,
   input  logic signed [AXIS_WIDTH-1:0] throttle_x,
   input  logic signed [AXIS_WIDTH-1:0] throttle_y,
   output jdds_pkg::step_type           step,
   output jdds_pkg::speed_type          left_mix,
   output jdds_pkg::speed_type          right_mix
);
   import jdds_pkg::*;

   localparam int SUM_W = (AXIS_WIDTH + 1 > 10) ? AXIS_WIDTH + 1 : 10;
   localparam logic signed [SUM_W-1:0] LIM_HI = SUM_W'(SPEED_LIMIT);
   localparam logic signed [SUM_W-1:0] LIM_LO = -LIM_HI;

   logic        paused_ff, paused_in;
   logic [4:0]  gov_ff, gov_in;
   profile_type profile_ff, profile_in;
   logic [6:0]  slew_ff, slew_in;
   logic [4:0]  brake_ff, brake_in;
   logic        link_ff, link_in;
   logic [4:0]  hist_ff, hist_in;
   logic        finished_ff, finished_in;
   step_type    step_ff, step_in;
   speed_type   left_ff, right_ff;

   logic signed [SUM_W-1:0] x_ext, y_ext, sum_l, sum_r, sh_l, sh_r;
   speed_type   cap_l, cap_r;

   // Mix, floor shift and cap.
   always_comb begin
      x_ext = SUM_W'(throttle_x);
      y_ext = SUM_W'(throttle_y);
      sum_l = x_ext + y_ext;
      sum_r = y_ext - x_ext;
      sh_l  = sum_l >>> MIX_SHIFT;
      sh_r  = sum_r >>> MIX_SHIFT;
      priority if (sh_l >= LIM_HI) cap_l = SPEED_CAP;
      else if (sh_l <= LIM_LO)     cap_l = -SPEED_CAP;
      else                         cap_l = sh_l[8:0];
      priority if (sh_r >= LIM_HI) cap_r = SPEED_CAP;
      else if (sh_r <= LIM_LO)     cap_r = -SPEED_CAP;
      else                         cap_r = sh_r[8:0];
   end

   // Link, exit, button edges, pause, governor and profile.
   always_comb begin
      logic [4:0]  now_lvl;
      logic [4:0]  rise;
      profile_type want;
      logic [6:0]  want_slew;
      logic [4:0]  want_brake;
      paused_in   = paused_ff;
      gov_in      = gov_ff;
      profile_in  = profile_ff;
      slew_in     = slew_ff;
      brake_in    = brake_ff;
      link_in     = link_ff;
      hist_in     = hist_ff;
      finished_in = finished_ff;
      step_in     = '0;
      now_lvl = {sample.slower_button, sample.faster_button, sample.estop_button,
                 sample.pause_button, sample.start_button};
      rise    = now_lvl & ~hist_ff;
      priority if (sample.trigger < TRIG_BAND_LOW) begin
         want = PROF_SLOW; want_slew = SLEW_SLOW; want_brake = BRAKE_SLOW;
      end else if (sample.trigger < TRIG_BAND_HIGH) begin
         want = PROF_MID;  want_slew = SLEW_MID;  want_brake = BRAKE_MID;
      end else begin
         want = PROF_FAST; want_slew = SLEW_FAST; want_brake = BRAKE_FAST;
      end
      if (!finished_ff) begin
         if (sample.linked != link_ff) begin
            link_in = sample.linked;
            if (!sample.linked) begin
               step_in.stop_issued = 1'b1;
            end
         end
         if (sample.linked) begin
            if (sample.exit_button && !exit_ignored) begin
               finished_in = 1'b1;
            end else begin
               hist_in[HIST_ESTOP:HIST_START] = now_lvl[HIST_ESTOP:HIST_START];
               if (rise[HIST_START]) begin
                  paused_in = 1'b0;
               end
               if (rise[HIST_PAUSE]) begin
                  if (!paused_in) begin
                     step_in.stop_issued = 1'b1;
                  end
                  paused_in = 1'b1;
               end
               if (rise[HIST_ESTOP]) begin
                  step_in.stop_issued  = 1'b1;
                  step_in.brake_forced = 1'b1;
                  brake_in             = BRAKE_ESTOP;
                  paused_in            = 1'b1;
               end
               if (!paused_in) begin
                  hist_in[HIST_SLOWER:HIST_FASTER] = now_lvl[HIST_SLOWER:HIST_FASTER];
                  if (rise[HIST_FASTER] && gov_in <= GOV_TOP) begin
                     gov_in = gov_in + 5'd1;
                  end
                  if (rise[HIST_SLOWER] && gov_in >= GOV_FLOOR) begin
                     gov_in = gov_in - 5'd1;
                  end
                  if (profile_ff != want) begin
                     slew_in                 = want_slew;
                     brake_in                = want_brake;
                     profile_in              = want;
                     step_in.profile_applied = 1'b1;
                  end
                  step_in.speeds_sent = 1'b1;
               end
            end
         end
      end
      step_in.slew_level     = slew_in;
      step_in.brake_level    = brake_in;
      step_in.paused_now     = paused_in;
      step_in.governor_now   = gov_in;
      step_in.exit_requested = finished_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         paused_ff   <= 1'b1;
         gov_ff      <= GOV_RESET;
         profile_ff  <= PROF_NONE;
         slew_ff     <= '0;
         brake_ff    <= '0;
         link_ff     <= 1'b0;
         hist_ff     <= '0;
         finished_ff <= 1'b0;
      end else if (advance) begin
         paused_ff   <= paused_in;
         gov_ff      <= gov_in;
         profile_ff  <= profile_in;
         slew_ff     <= slew_in;
         brake_ff    <= brake_in;
         link_ff     <= link_in;
         hist_ff     <= hist_in;
         finished_ff <= finished_in;
      end
   end

   // The left side runs reversed, so its sign flips here.
   always_ff @(posedge clock) begin
      if (advance) begin
         step_ff  <= step_in;
         left_ff  <= -cap_l;
         right_ff <= cap_r;
      end
   end

   assign step      = step_ff;
   assign left_mix  = left_ff;
   assign right_mix = right_ff;

endmodule
`default_nettype wire

FILE: rtl/jdds_scale.sv
`default_nettype none
module jdds_scale (
   input  logic                clock,
   input  logic                load,
   input  jdds_pkg::speed_type mix,
   input  logic [4:0]          governor,
   output jdds_pkg::speed_type scaled
);
   import jdds_pkg::*;

   logic [MAG_W-1:0] prod_ff;
   logic             neg_ff;
   logic [7:0]       mag;
   logic [MAG_W-3:0] quarter;
   logic [MAG_W-3+MAG_W:0] recip_prod;
   logic [7:0]       quot;

   // Work on the magnitude so the quotient truncates toward zero.
   always_comb begin
      mag = mix[8] ? 8'(-mix) : mix[7:0];
   end

   always_ff @(posedge clock) begin
      if (load) begin
         prod_ff <= MAG_W'(mag * governor);
         neg_ff  <= mix[8];
      end
   end

   always_comb begin
      quarter    = prod_ff[MAG_W-1:2];
      recip_prod = quarter * RECIP_FIVE;
      quot       = recip_prod[RECIP_SHIFT+7:RECIP_SHIFT];
      scaled     = neg_ff ? -speed_type'({1'b0, quot}) : speed_type'({1'b0, quot});
   end

endmodule
`default_nettype wire

FILE: sim/testbench.sv
`timescale 1ns / 1ps

// Self-checking bench for the joystick differential-drive shaper.
// A stimulus process fills a queue of pending operations: controller sample
// requests, writes to the exit_ignored register and drain points where the
// sender holds off until every outstanding command has come back. A clocked
// driver feeds that queue onto the request channel; a clocked monitor predicts
// the drive command for every accepted request and compares every accepted
// command against the oldest prediction, field by field.
module testbench;

   import jdds_pkg::*;

   localparam int MIX_SHIFT      = 7;
   localparam int GOV_DIVISOR    = 20;
   localparam int IDLE_PERCENT   = 18;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int REPORT_LIMIT   = 10;

   // Button masks used when building sample requests.
   localparam logic [5:0] BTN_EXIT   = 6'b000001;
   localparam logic [5:0] BTN_START  = 6'b000010;
   localparam logic [5:0] BTN_PAUSE  = 6'b000100;
   localparam logic [5:0] BTN_ESTOP  = 6'b001000;
   localparam logic [5:0] BTN_FASTER = 6'b010000;
   localparam logic [5:0] BTN_SLOWER = 6'b100000;
   localparam logic [5:0] BTN_ALL    = 6'b111111;

   // Request layout, low bit up: linked, exit, start, pause, estop, faster,
   // slower, throttle_x, throttle_y, trigger, one bit of zero fill.
   typedef struct packed {
      logic              fill;
      logic [7:0]        trigger;
      logic signed [15:0] throttle_y;
      logic signed [15:0] throttle_x;
      logic              slower_button;
      logic              faster_button;
      logic              estop_button;
      logic              pause_button;
      logic              start_button;
      logic              exit_button;
      logic              linked;
   } sample_word_t;

   // Command layout, low bit up, as the block packs it onto rsp_tdata.
   typedef struct packed {
      logic [6:0]        fill;
      logic              exit_requested;
      logic [4:0]        governor_now;
      logic              paused_now;
      logic signed [8:0] right_speed;
      logic signed [8:0] left_speed;
      logic              speeds_sent;
      logic [4:0]        brake_level;
      logic [6:0]        slew_level;
      logic              profile_applied;
      logic              brake_forced;
      logic              stop_issued;
   } drive_cmd_t;

   typedef enum logic [1:0] {
      DO_SAMPLE,
      DO_WRITE,
      DO_DRAIN
   } op_kind_t;

   typedef struct packed {
      op_kind_t     kind;
      sample_word_t sample;
      logic         value;
   } pending_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic        csr_wr_en = 1'b0;
   logic        csr_wr_data = 1'b0;

   pending_t   pending_ops[$];
   drive_cmd_t expected_cmds[$];

   int samples_taken = 0;
   int commands_seen = 0;
   int faults = 0;
   int quiet_cycles = 0;

   // Button and link levels carried from one random request to the next, so
   // that presses are held for a while like a real hand would.
   logic       held_link = 1'b0;
   logic [5:0] held_buttons = '0;

   // Predicted state of the shaper.
   logic        exit_masked;
   logic        run_paused;
   logic [4:0]  gov_level;
   profile_type active_profile;
   logic [6:0]  slew_now;
   logic [4:0]  brake_now;
   logic        link_up;
   logic [4:0]  button_prev;
   logic signed [8:0] left_now;
   logic signed [8:0] right_now;
   logic        shut_down;

   // A stretch of requests during which neither side idles at random.
   wire steady_run = samples_taken >= 400 && samples_taken < 650;

   // Nothing in flight: no request offered, no register write pending and
   // every accepted request has produced its command.
   wire pipe_empty = !req_tvalid && !csr_wr_en && samples_taken == commands_seen;

   joystick_differential_drive_shaper_core uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // The mix is capped symmetrically before the governor is applied.
   function automatic int clamp_speed(int v);
      if (v >= SPEED_LIMIT) return int'(SPEED_CAP);
      if (v <= -SPEED_LIMIT) return -int'(SPEED_CAP);
      return v;
   endfunction

   // Advances the predicted state by one sample and returns the command the
   // block must answer with.
   function automatic drive_cmd_t shape_sample(sample_word_t s);
      drive_cmd_t  cmd;
      logic [4:0]  levels;
      logic [4:0]  rise;
      profile_type want;
      logic [6:0]  new_slew;
      logic [4:0]  new_brake;
      int          x;
      int          y;
      int          mix_l;
      int          mix_r;
      int          g;
      cmd = '0;
      if (!shut_down) begin
         // Dropping the link stops the motors; regaining it does nothing more.
         if (s.linked != link_up) begin
            link_up = s.linked;
            if (!s.linked) begin
               left_now = '0;
               right_now = '0;
               cmd.stop_issued = 1'b1;
            end
         end
         if (link_up) begin
            if (s.exit_button && !exit_masked) begin
               shut_down = 1'b1;
            end else begin
               levels[HIST_START]  = s.start_button;
               levels[HIST_PAUSE]  = s.pause_button;
               levels[HIST_ESTOP]  = s.estop_button;
               levels[HIST_FASTER] = s.faster_button;
               levels[HIST_SLOWER] = s.slower_button;
               rise = levels & ~button_prev;
               button_prev[HIST_START] = levels[HIST_START];
               button_prev[HIST_PAUSE] = levels[HIST_PAUSE];
               button_prev[HIST_ESTOP] = levels[HIST_ESTOP];
               if (rise[HIST_START]) run_paused = 1'b0;
               // Pause is checked after start, so it wins when both rise.
               if (rise[HIST_PAUSE]) begin
                  if (!run_paused) begin
                     left_now = '0;
                     right_now = '0;
                     cmd.stop_issued = 1'b1;
                  end
                  run_paused = 1'b1;
               end
               if (rise[HIST_ESTOP]) begin
                  left_now = '0;
                  right_now = '0;
                  cmd.stop_issued = 1'b1;
                  cmd.brake_forced = 1'b1;
                  brake_now = BRAKE_ESTOP;
                  run_paused = 1'b1;
               end
               if (!run_paused) begin
                  // The governor buttons are only tracked while running.
                  button_prev[HIST_FASTER] = levels[HIST_FASTER];
                  button_prev[HIST_SLOWER] = levels[HIST_SLOWER];
                  if (rise[HIST_FASTER] && gov_level <= GOV_TOP) gov_level = gov_level + 1'b1;
                  if (rise[HIST_SLOWER] && gov_level >= GOV_FLOOR) gov_level = gov_level - 1'b1;
                  if (s.trigger < TRIG_BAND_LOW) begin
                     want = PROF_SLOW;
                     new_slew = SLEW_SLOW;
                     new_brake = BRAKE_SLOW;
                  end else if (s.trigger < TRIG_BAND_HIGH) begin
                     want = PROF_MID;
                     new_slew = SLEW_MID;
                     new_brake = BRAKE_MID;
                  end else begin
                     want = PROF_FAST;
                     new_slew = SLEW_FAST;
                     new_brake = BRAKE_FAST;
                  end
                  if (active_profile != want) begin
                     slew_now = new_slew;
                     brake_now = new_brake;
                     active_profile = want;
                     cmd.profile_applied = 1'b1;
                  end
                  x = $signed(s.throttle_x);
                  y = $signed(s.throttle_y);
                  mix_l = clamp_speed((x + y) >>> MIX_SHIFT);
                  mix_r = clamp_speed((y - x) >>> MIX_SHIFT);
                  g = int'(gov_level);
                  // Integer division truncates toward zero, as required.
                  left_now = (-mix_l * g) / GOV_DIVISOR;
                  right_now = (mix_r * g) / GOV_DIVISOR;
                  cmd.speeds_sent = 1'b1;
               end
            end
         end
      end
      cmd.slew_level = slew_now;
      cmd.brake_level = brake_now;
      cmd.left_speed = left_now;
      cmd.right_speed = right_now;
      cmd.paused_now = run_paused;
      cmd.governor_now = gov_level;
      cmd.exit_requested = shut_down;
      return cmd;
   endfunction

   task automatic check_field(string name, integer want, integer got);
      if (want !== got) begin
         faults++;
         if (faults <= REPORT_LIMIT)
            $display("command %0d: %s expected %0d, got %0d", commands_seen, name, want, got);
      end
   endtask

   task automatic check_command(drive_cmd_t want, drive_cmd_t got);
      check_field("stop_issued", want.stop_issued, got.stop_issued);
      check_field("brake_forced", want.brake_forced, got.brake_forced);
      check_field("profile_applied", want.profile_applied, got.profile_applied);
      check_field("slew_level", want.slew_level, got.slew_level);
      check_field("brake_level", want.brake_level, got.brake_level);
      check_field("speeds_sent", want.speeds_sent, got.speeds_sent);
      check_field("left_speed", want.left_speed, got.left_speed);
      check_field("right_speed", want.right_speed, got.right_speed);
      check_field("paused_now", want.paused_now, got.paused_now);
      check_field("governor_now", want.governor_now, got.governor_now);
      check_field("exit_requested", want.exit_requested, got.exit_requested);
      check_field("zero fill", want.fill, got.fill);
   endtask

   task automatic push_sample(logic lnk, logic [5:0] btn, int x, int y, int trig);
      pending_t op;
      op = '0;
      op.kind = DO_SAMPLE;
      op.sample.linked = lnk;
      op.sample.exit_button = |(btn & BTN_EXIT);
      op.sample.start_button = |(btn & BTN_START);
      op.sample.pause_button = |(btn & BTN_PAUSE);
      op.sample.estop_button = |(btn & BTN_ESTOP);
      op.sample.faster_button = |(btn & BTN_FASTER);
      op.sample.slower_button = |(btn & BTN_SLOWER);
      op.sample.throttle_x = x[15:0];
      op.sample.throttle_y = y[15:0];
      op.sample.trigger = trig[7:0];
      pending_ops.push_back(op);
   endtask

   task automatic push_write(logic v);
      pending_t op;
      op = '0;
      op.kind = DO_WRITE;
      op.value = v;
      pending_ops.push_back(op);
   endtask

   task automatic push_drain();
      pending_t op;
      op = '0;
      op.kind = DO_DRAIN;
      pending_ops.push_back(op);
   endtask

   // Presses a released button with one chance and releases a held one with
   // another, in percent.
   function automatic logic [5:0] roll_button(logic [5:0] levels, logic [5:0] mask,
                                              int press, int drop);
      logic held;
      held = |(levels & mask);
      if (held ? ($urandom_range(99) >= drop) : ($urandom_range(99) < press))
         return levels | mask;
      return levels & ~mask;
   endfunction

   function automatic int clamp_axis(int v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
   endfunction

   // Random requests shaped like real driving: mostly linked, start pressed
   // now and then so the block spends much of its time running, occasional
   // pauses, emergency stops and link drops. When exit_live is clear the
   // exit button is only ever pressed while the link is down.
   task automatic random_phase(int count, logic exit_live);
      int faster_bias;
      int slower_bias;
      int x;
      int y;
      int trig;
      int target;
      int axis_marks[7];
      int trig_marks[6];
      logic [5:0] btn;
      axis_marks = '{-32768, -32767, -1, 0, 1, 32766, 32767};
      trig_marks = '{0, 79, 80, 159, 160, 255};
      faster_bias = 12;
      slower_bias = 12;
      for (int i = 0; i < count; i++) begin
         // Lean the governor one way or the other so both ends get reached.
         if (i % 60 == 0) begin
            case ($urandom_range(2))
               0: begin faster_bias = 35; slower_bias = 3; end
               1: begin faster_bias = 3; slower_bias = 35; end
               default: begin faster_bias = 12; slower_bias = 12; end
            endcase
         end
         held_link = $urandom_range(99) < (held_link ? 98 : 40);
         held_buttons = roll_button(held_buttons, BTN_EXIT, 5, 50);
         held_buttons = roll_button(held_buttons, BTN_START, 10, 40);
         held_buttons = roll_button(held_buttons, BTN_PAUSE, 3, 50);
         held_buttons = roll_button(held_buttons, BTN_ESTOP, 2, 50);
         held_buttons = roll_button(held_buttons, BTN_FASTER, faster_bias, 40);
         held_buttons = roll_button(held_buttons, BTN_SLOWER, slower_bias, 40);
         btn = (!exit_live && held_link) ? (held_buttons & ~BTN_EXIT) : held_buttons;
         case ($urandom_range(4))
            0, 1: begin
               x = $urandom_range(65535) - 32768;
               y = $urandom_range(65535) - 32768;
            end
            2: begin
               x = axis_marks[$urandom_range(6)];
               y = axis_marks[$urandom_range(6)];
            end
            3: begin
               x = $urandom_range(800) - 400;
               y = $urandom_range(800) - 400;
            end
            default: begin
               // Land one of the mixes close to the speed cap.
               target = ($urandom_range(1) ? 32000 : -32000) + $urandom_range(600) - 300;
               x = $urandom_range(32767) - 16384;
               y = clamp_axis($urandom_range(1) ? target - x : target + x);
            end
         endcase
         trig = $urandom_range(1) ? $urandom_range(255) : trig_marks[$urandom_range(5)];
         push_sample(held_link, btn, x, y, trig);
         if (i == count / 2 || $urandom_range(199) == 0) push_drain();
      end
   endtask

   initial begin
      // Directed requests. The register still holds its reset value here, so
      // the first request checks that buttons are ignored without a link.
      push_sample(1'b0, BTN_ALL, -32768, 32767, 255);
      push_write(1'b1);
      // Link comes up with exit held; exit is ignored now.
      push_sample(1'b1, BTN_EXIT, 0, 0, 0);
      // Start with both axes at the positive end: left mix is capped.
      push_sample(1'b1, BTN_START | BTN_EXIT, 32767, 32767, 0);
      // Faster edge, lowest band edge, both axes at the negative end.
      push_sample(1'b1, BTN_START | BTN_FASTER, -32768, -32768, 79);
      push_sample(1'b1, BTN_START, -32768, 32767, 80);
      // Small mixes where the floor shift and truncation toward zero differ.
      push_sample(1'b1, 6'b0, 127, -1, 159);
      push_sample(1'b1, 6'b0, 896, 0, 159);
      push_sample(1'b1, BTN_SLOWER, 896, 0, 160);
      // Same band again: no new profile.
      push_sample(1'b1, 6'b0, 32767, -32768, 255);
      push_sample(1'b1, BTN_PAUSE, 1000, 1000, 255);
      // Faster pressed while paused is remembered as released.
      push_sample(1'b1, BTN_PAUSE | BTN_FASTER, 1000, 1000, 255);
      push_sample(1'b1, BTN_START | BTN_PAUSE | BTN_FASTER, -2000, 7000, 200);
      push_sample(1'b1, BTN_FASTER, -2000, 7000, 200);
      // Start and pause rising together: pause wins and stops the motors.
      push_sample(1'b1, BTN_START | BTN_PAUSE, 3000, 3000, 200);
      push_sample(1'b1, 6'b0, 3000, 3000, 200);
      push_sample(1'b1, BTN_ESTOP, 3000, 3000, 200);
      // Resume in the same band: the emergency brake stays in force.
      push_sample(1'b1, BTN_START | BTN_ESTOP, 5000, -3000, 255);
      // Link loss stops the motors; buttons are ignored while unlinked.
      push_sample(1'b0, BTN_START, 5000, -3000, 255);
      push_sample(1'b0, BTN_PAUSE | BTN_SLOWER, 5000, -3000, 255);
      // Start is still held across the outage, so this is no new edge.
      push_sample(1'b1, BTN_START, 300, 300, 30);
      push_sample(1'b1, BTN_START | BTN_SLOWER, 300, 300, 30);
      push_sample(1'b1, BTN_ESTOP, -300, 300, 30);
      push_drain();

      // Random phases, alternating the exit_ignored setting.
      for (int p = 0; p < 8; p++) begin
         push_write(p[0]);
         random_phase(140, p[0]);
      end

      // Last phase: exit is honored, and everything after it is ignored.
      push_write(1'b0);
      random_phase(20, 1'b0);
      push_sample(1'b1, 6'b0, 1234, -4321, 100);
      push_sample(1'b1, BTN_EXIT | BTN_START, 1234, -4321, 100);
      random_phase(30, 1'b1);

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      while (pending_ops.size() != 0 || req_tvalid || samples_taken != commands_seen)
         @(posedge clock);
      repeat (8) @(posedge clock);
      if (expected_cmds.size() != 0)
         $display("%0d commands never arrived", expected_cmds.size());
      if (faults == 0 && expected_cmds.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   // Request driver. A new operation is taken from the queue only when the
   // request slot is free; register writes and drain points wait until the
   // pipeline has emptied.
   always @(posedge clock) begin : feed_requests
      logic         next_valid;
      logic [47:0]  next_data;
      logic         next_wen;
      logic         next_wdata;
      pending_t     head;
      next_valid = req_tvalid;
      next_data = req_tdata;
      next_wen = 1'b0;
      next_wdata = csr_wr_data;
      if (reset) begin
         next_valid = 1'b0;
      end else if (!req_tvalid || req_tready) begin
         next_valid = 1'b0;
         if (pending_ops.size() != 0) begin
            head = pending_ops[0];
            case (head.kind)
               DO_SAMPLE: begin
                  if (steady_run || $urandom_range(99) >= IDLE_PERCENT) begin
                     next_valid = 1'b1;
                     next_data = head.sample;
                     void'(pending_ops.pop_front());
                  end
               end
               DO_WRITE: begin
                  if (pipe_empty) begin
                     next_wen = 1'b1;
                     next_wdata = head.value;
                     void'(pending_ops.pop_front());
                  end
               end
               default: begin
                  if (pipe_empty) void'(pending_ops.pop_front());
               end
            endcase
         end
      end
      req_tvalid <= next_valid;
      req_tdata <= next_data;
      csr_wr_en <= next_wen;
      csr_wr_data <= next_wdata;
   end

   // The command side stalls at random, except during the steady stretch.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= steady_run || $urandom_range(99) >= IDLE_PERCENT;
      end
   end

   // Monitor: tracks register writes, predicts a command for every accepted
   // request and checks every accepted command against the oldest prediction.
   always @(posedge clock) begin : watch_channels
      drive_cmd_t want;
      drive_cmd_t got;
      if (reset) begin
         exit_masked = 1'b0;
         run_paused = 1'b1;
         gov_level = GOV_RESET;
         active_profile = PROF_NONE;
         slew_now = '0;
         brake_now = '0;
         link_up = 1'b0;
         button_prev = '0;
         left_now = '0;
         right_now = '0;
         shut_down = 1'b0;
      end else begin
         if (csr_wr_en) exit_masked = csr_wr_data;
         if (rsp_tvalid && rsp_tready) begin
            got = drive_cmd_t'(rsp_tdata);
            if (expected_cmds.size() == 0) begin
               faults++;
               if (faults <= REPORT_LIMIT)
                  $display("command %0d arrived with nothing expected: %h",
                           commands_seen, rsp_tdata);
            end else begin
               want = expected_cmds.pop_front();
               check_command(want, got);
            end
            commands_seen <= commands_seen + 1;
         end
         if (req_tvalid && req_tready) begin
            expected_cmds.push_back(shape_sample(sample_word_t'(req_tdata)));
            samples_taken <= samples_taken + 1;
         end
      end
   end

   // Watchdog: too many cycles without any transfer ends the run.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_wr_en) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("no transfer for %0d cycles", quiet_cycles);
         $display("CHECK FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule

FILE: joystick_differential_drive_shaper_core.f
+incdir+rtl
rtl/jdds_pkg.sv
rtl/jdds_ctrl.sv
rtl/jdds_scale.sv
rtl/joystick_differential_drive_shaper_core.sv
sim/testbench.sv
